[rtl/i2cee_pkg.sv]
// i2cee_pkg: shared types and constants for the two-wire EEPROM slave core.
// Used by i2cee_ctrl, i2cee_dp and i2c_eeprom_2kb_slave_core. No dependencies.
`timescale 1ns / 1ps

package i2cee_pkg;

  localparam int PORT_W = 8;
  localparam int ADDR_W = 11;
  localparam int BITS_W = 4;
  localparam int FILL_W = 4;
  localparam int PH_W   = 2;

  localparam int SDA_BIT = 4;
  localparam int WP_BIT  = 5;
  localparam int SCL_BIT = 6;

  localparam logic [PH_W-1:0] PH_IDLE    = 2'd0;
  localparam logic [PH_W-1:0] PH_SELECT  = 2'd1;
  localparam logic [PH_W-1:0] PH_ADDRESS = 2'd2;
  localparam logic [PH_W-1:0] PH_WRITE   = 2'd3;

  localparam logic [3:0]        DEV_TYPE   = 4'hA;
  localparam logic [7:0]        PAGE_END   = 8'hFF;
  localparam logic [ADDR_W-1:0] BLOCK_MASK = 11'h700;
  localparam logic [BITS_W-1:0] BYTE_BITS  = 4'd8;

  typedef struct packed {
    logic capture;
    logic exec;
    logic fetch_load;
    logic commit_step;
    logic clear_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic fetch_need;
    logic commit_need;
    logic commit_last;
    logic clear_last;
  } dp_stat_t;

endpackage

[rtl/i2cee_dp.sv]
// i2cee_dp: bus decode, shift register, page buffer and EEPROM array.
// Driven by i2cee_ctrl through i2cee_pkg::dp_cmd_t; reports i2cee_pkg::dp_stat_t.
`timescale 1ns / 1ps

module i2cee_dp #(
  parameter int MEM_BYTES  = 2048,
  parameter int PAGE_BYTES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  i2cee_pkg::dp_cmd_t            cmd,
  output i2cee_pkg::dp_stat_t           stat,
  input  logic [i2cee_pkg::PORT_W-1:0]  port_value,
  output logic                          data_line_out
);

  localparam int MEM_AW = $clog2(MEM_BYTES);
  localparam int PG_AW  = $clog2(PAGE_BYTES);
  localparam logic [13:0] M1 = 14'(MEM_BYTES);
  localparam logic [13:0] M2 = 14'(2 * MEM_BYTES);
  localparam logic [13:0] M4 = 14'(4 * MEM_BYTES);

  function automatic logic [MEM_AW-1:0] mem_idx(input logic [i2cee_pkg::ADDR_W-1:0] a);
    logic [13:0] r;
    r = 14'(a);
    if (r >= M4) r = r - M4;
    if (r >= M2) r = r - M2;
    if (r >= M1) r = r - M1;
    return r[MEM_AW-1:0];
  endfunction

  function automatic logic [i2cee_pkg::ADDR_W-1:0] page_adv(
      input logic [i2cee_pkg::ADDR_W-1:0] a);
    if (a[7:0] == i2cee_pkg::PAGE_END) return a & i2cee_pkg::BLOCK_MASK;
    else return a + 11'd1;
  endfunction

  logic sda_in_r, wp_in_r, scl_in_r;
  logic last_sda_r, last_sda_nxt;
  logic last_scl_r, last_scl_nxt;
  logic [i2cee_pkg::PH_W-1:0] phase_r, phase_nxt;
  logic start_seen_r, start_seen_nxt;
  logic tx_r, tx_nxt;
  logic rx_r, rx_nxt;
  logic ack_r, ack_nxt;
  logic [i2cee_pkg::BITS_W-1:0] bits_r, bits_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [i2cee_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic [i2cee_pkg::FILL_W-1:0] fill_r, fill_nxt;
  logic [PG_AW-1:0] k_r, k_nxt;
  logic [MEM_AW-1:0] clr_r;
  logic [7:0] page_r [PAGE_BYTES];
  logic [7:0] mem [MEM_BYTES];
  logic [7:0] rdata_r;
  logic out_r;

  logic rise, high, fall, start_c, stop_c;
  logic [7:0] nshift;
  logic [i2cee_pkg::BITS_W-1:0] nbits;
  logic pb_we;
  logic mem_we;
  logic [MEM_AW-1:0] mem_waddr;
  logic [7:0] mem_wdata;
  logic [PG_AW-1:0] fill_idx, fill_last;

  assign rise    = !last_scl_r && scl_in_r;
  assign high    = last_scl_r && scl_in_r;
  assign fall    = last_scl_r && !scl_in_r;
  assign start_c = high && last_sda_r && !sda_in_r;
  assign stop_c  = high && !last_sda_r && sda_in_r;
  assign nshift  = {shift_r[6:0], last_sda_r};
  assign nbits   = bits_r - 4'd1;
  assign fill_idx  = fill_r[PG_AW-1:0];
  assign fill_last = PG_AW'(fill_idx - 1'b1);

  assign stat.fetch_need  = rise && tx_r && !ack_r && (bits_r == '0);
  assign stat.commit_need = stop_c && (phase_r == i2cee_pkg::PH_WRITE) && !wp_in_r &&
                            (fill_r != '0);
  assign stat.commit_last = (k_r == fill_last);
  assign stat.clear_last  = (clr_r == MEM_AW'(MEM_BYTES - 1));

  always_comb begin
    last_sda_nxt   = last_sda_r;
    last_scl_nxt   = last_scl_r;
    phase_nxt      = phase_r;
    start_seen_nxt = start_seen_r;
    tx_nxt         = tx_r;
    rx_nxt         = rx_r;
    ack_nxt        = ack_r;
    bits_nxt       = bits_r;
    shift_nxt      = shift_r;
    addr_nxt       = addr_r;
    fill_nxt       = fill_r;
    k_nxt          = k_r;
    pb_we          = 1'b0;
    if (cmd.exec) begin
      k_nxt        = '0;
      last_sda_nxt = sda_in_r;
      last_scl_nxt = scl_in_r;
      if (rise) begin
        start_seen_nxt = 1'b1;
      end else if (start_c) begin
        start_seen_nxt = 1'b0;
        tx_nxt         = 1'b0;
        rx_nxt         = 1'b1;
        phase_nxt      = i2cee_pkg::PH_SELECT;
        bits_nxt       = i2cee_pkg::BYTE_BITS;
      end else if (stop_c) begin
        phase_nxt      = i2cee_pkg::PH_IDLE;
        start_seen_nxt = 1'b0;
        rx_nxt         = 1'b0;
        tx_nxt         = 1'b0;
      end else if (fall) begin
        if (ack_r) begin
          ack_nxt = 1'b0;
        end else if (tx_r) begin
          shift_nxt = {shift_r[6:0], 1'b0};
        end else if (rx_r && start_seen_r) begin
          shift_nxt = nshift;
          bits_nxt  = nbits;
          if (nbits == '0) begin
            unique case (phase_r)
              i2cee_pkg::PH_SELECT: begin
                if (nshift[7:4] == i2cee_pkg::DEV_TYPE) begin
                  if (nshift[0]) begin
                    bits_nxt = '0;
                    rx_nxt   = 1'b0;
                    tx_nxt   = 1'b1;
                  end else begin
                    addr_nxt  = {nshift[3:1], addr_r[7:0]};
                    bits_nxt  = i2cee_pkg::BYTE_BITS;
                    phase_nxt = i2cee_pkg::PH_ADDRESS;
                  end
                  ack_nxt = 1'b1;
                end else begin
                  phase_nxt      = i2cee_pkg::PH_IDLE;
                  start_seen_nxt = 1'b0;
                  rx_nxt         = 1'b0;
                  tx_nxt         = 1'b0;
                  ack_nxt        = 1'b0;
                end
              end
              i2cee_pkg::PH_ADDRESS: begin
                addr_nxt  = {addr_r[10:8], nshift};
                bits_nxt  = i2cee_pkg::BYTE_BITS;
                phase_nxt = i2cee_pkg::PH_WRITE;
                ack_nxt   = 1'b1;
                fill_nxt  = '0;
              end
              i2cee_pkg::PH_WRITE: begin
                pb_we    = 1'b1;
                fill_nxt = (fill_idx == PG_AW'(PAGE_BYTES - 1)) ? '0 : fill_r + 4'd1;
                bits_nxt = i2cee_pkg::BYTE_BITS;
                ack_nxt  = 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
      end
    end
    if (cmd.fetch_load) begin
      shift_nxt = rdata_r;
      addr_nxt  = addr_r + 11'd1;
      bits_nxt  = i2cee_pkg::BYTE_BITS;
    end
    if (cmd.commit_step) begin
      addr_nxt = page_adv(addr_r);
      k_nxt    = k_r + 1'b1;
    end
  end

  always_comb begin
    mem_we    = cmd.clear_step || cmd.commit_step;
    mem_waddr = cmd.clear_step ? clr_r : mem_idx(addr_r);
    mem_wdata = cmd.clear_step ? 8'h00 : page_r[k_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sda_r   <= 1'b1;
      last_scl_r   <= 1'b1;
      phase_r      <= i2cee_pkg::PH_IDLE;
      start_seen_r <= 1'b0;
      tx_r         <= 1'b0;
      rx_r         <= 1'b0;
      ack_r        <= 1'b0;
      bits_r       <= '0;
      shift_r      <= '0;
      addr_r       <= '0;
      fill_r       <= '0;
      k_r          <= '0;
      clr_r        <= '0;
    end else begin
      last_sda_r   <= last_sda_nxt;
      last_scl_r   <= last_scl_nxt;
      phase_r      <= phase_nxt;
      start_seen_r <= start_seen_nxt;
      tx_r         <= tx_nxt;
      rx_r         <= rx_nxt;
      ack_r        <= ack_nxt;
      bits_r       <= bits_nxt;
      shift_r      <= shift_nxt;
      addr_r       <= addr_nxt;
      fill_r       <= fill_nxt;
      k_r          <= k_nxt;
      if (cmd.clear_step) clr_r <= clr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sda_in_r <= port_value[i2cee_pkg::SDA_BIT];
      wp_in_r  <= port_value[i2cee_pkg::WP_BIT];
      scl_in_r <= port_value[i2cee_pkg::SCL_BIT];
    end
    if (pb_we) page_r[fill_idx] <= nshift;
    if (cmd.out_load) begin
      out_r <= (!ack_r && (phase_r != i2cee_pkg::PH_IDLE) && tx_r) ? shift_r[7] : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_r <= mem[mem_idx(addr_r)];
  end

  assign data_line_out = out_r;

  a_fetch_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fetch_load |-> $past(cmd.exec) && $past(stat.fetch_need))
    else $error("fetch load without a rising clock fetch");

  a_commit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit_step |-> fill_r != '0 && k_r <= fill_last)
    else $error("commit beyond page fill");

  a_commit_runs: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit_step && !stat.commit_last |=> cmd.commit_step)
    else $error("page commit cut short");

endmodule

[rtl/i2cee_ctrl.sv]
// i2cee_ctrl: sequencer for array clearing, item decode, read fetch, page
// commit and result hand-off. Uses i2cee_pkg command and status types.
`timescale 1ns / 1ps

module i2cee_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output i2cee_pkg::dp_cmd_t  cmd,
  input  i2cee_pkg::dp_stat_t stat
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_FETCH  = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;
  logic accept;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cmd.capture = accept;
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.fetch_need) state_nxt = S_FETCH;
        else if (stat.commit_need) state_nxt = S_COMMIT;
        else state_nxt = S_DONE;
      end
      S_FETCH: begin
        cmd.fetch_load = 1'b1;
        state_nxt      = S_DONE;
      end
      S_COMMIT: begin
        cmd.commit_step = 1'b1;
        if (stat.commit_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.out_load = out_free;
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_EXEC)
    else $error("accepted item not decoded next cycle");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r && state_r == S_IDLE)
    else $error("result load lost");

  a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && out_valid_r && out_stall |=> state_r == S_DONE)
    else $error("result overwrote a waiting item");

endmodule

[rtl/i2c_eeprom_2kb_slave_core.sv]
// i2c_eeprom_2kb_slave_core: top level of the two-wire serial EEPROM slave.
// Instantiates i2cee_ctrl and i2cee_dp; types from i2cee_pkg.
//
//   channel | handshake             | payload
//   in      | in_valid / in_stall   | in_port_value[7:0] (bit4 SDA, bit5 WP, bit6 SCL)
//   out     | out_valid / out_stall | out_data_line_out
//
// An item passes from accept to result through capture, decode and result load.
// A rising clock that starts a read byte adds an array read step before the result load.
// A STOP after a page write adds a commit step for each buffered byte (up to PAGE_BYTES-1).
// After reset a clearing pass over all MEM_BYTES addresses zeroes the array; in_stall stays high.
// The next item is taken while a result waits on out_stall; a further result waits.
`timescale 1ns / 1ps

module i2c_eeprom_2kb_slave_core #(
  parameter int MEM_BYTES  = 2048,
  parameter int PAGE_BYTES = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [i2cee_pkg::PORT_W-1:0] in_port_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_data_line_out
);

  i2cee_pkg::dp_cmd_t  cmd;
  i2cee_pkg::dp_stat_t stat;

  i2cee_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  i2cee_dp #(
    .MEM_BYTES  (MEM_BYTES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .port_value    (in_port_value),
    .data_line_out (out_data_line_out)
  );

endmodule

[test/tb_i2c_eeprom_2kb_slave_core.sv]
// Testbench for i2c_eeprom_2kb_slave_core: drives two-wire bus port items and
// checks the slave's driven data line against an in-bench model of the EEPROM.
// Depends on i2cee_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_i2c_eeprom_2kb_slave_core;

  localparam int MEM_BYTES   = 2048;
  localparam int PAGE_BYTES  = 16;
  localparam int N_RANDOM    = 700;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int FROM_MODEL  = -1;

  typedef struct {
    logic [i2cee_pkg::PORT_W-1:0] port;
    int                           typed;
  } port_row_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [i2cee_pkg::PORT_W-1:0] in_port_value = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic                         out_data_line_out;

  i2c_eeprom_2kb_slave_core #(
    .MEM_BYTES (MEM_BYTES),
    .PAGE_BYTES(PAGE_BYTES)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_port_value    (in_port_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data_line_out(out_data_line_out)
  );

  always #2 clk = ~clk;

  // EEPROM model state
  logic                         sda_q, scl_q, started, tx_on, rx_on, ack_wait;
  logic [i2cee_pkg::PH_W-1:0]   ph;
  logic [i2cee_pkg::BITS_W-1:0] bit_cnt;
  logic [7:0]                   shreg;
  logic [i2cee_pkg::ADDR_W-1:0] ee_addr;
  logic [i2cee_pkg::FILL_W-1:0] fill_cnt;
  logic [7:0]                   pg_buf [PAGE_BYTES];
  logic [7:0]                   ee_mem [MEM_BYTES];

  port_row_t port_seq [$];
  logic      drive_exp_q [$];
  logic      wp_now = 1'b0;
  logic      hold_off = 1'b0;
  int        n_acc = 0;
  int        n_out = 0;
  int        n_err = 0;
  int        rx_wait = 0;
  int        rx_mode = 1;
  int        cyc_cnt = 0;

  // after reset, extremes, then a select byte with the wrong device type
  port_row_t dir_rows [25] = '{
    '{8'h70, 0}, '{8'h8F, 0}, '{8'hFF, 0}, '{8'h00, 0}, '{8'h50, 0}, '{8'h40, 0},
    '{8'h00, FROM_MODEL}, '{8'h40, FROM_MODEL}, '{8'h10, FROM_MODEL}, '{8'h50, FROM_MODEL},
    '{8'h00, FROM_MODEL}, '{8'h40, FROM_MODEL}, '{8'h10, FROM_MODEL}, '{8'h50, FROM_MODEL},
    '{8'h00, FROM_MODEL}, '{8'h40, FROM_MODEL}, '{8'h00, FROM_MODEL}, '{8'h40, FROM_MODEL},
    '{8'h00, FROM_MODEL}, '{8'h40, FROM_MODEL}, '{8'h00, FROM_MODEL}, '{8'h40, FROM_MODEL},
    '{8'h00, 0}, '{8'h40, 0}, '{8'h50, 0}
  };

  function automatic int pick_wait(int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 18);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
    endcase
  endfunction

  task automatic flag_error(input string msg);
    n_err++;
    if (n_err <= 10) $display("%s", msg);
  endtask

  task automatic finish_byte();
    case (ph)
      i2cee_pkg::PH_SELECT: begin
        if (shreg[7:4] == i2cee_pkg::DEV_TYPE) begin
          if (shreg[0]) begin
            bit_cnt = '0;
            rx_on   = 1'b0;
            tx_on   = 1'b1;
          end else begin
            ee_addr = {shreg[3:1], ee_addr[7:0]};
            bit_cnt = i2cee_pkg::BYTE_BITS;
            ph      = i2cee_pkg::PH_ADDRESS;
          end
          ack_wait = 1'b1;
        end else begin
          ph       = i2cee_pkg::PH_IDLE;
          started  = 1'b0;
          rx_on    = 1'b0;
          tx_on    = 1'b0;
          ack_wait = 1'b0;
        end
      end
      i2cee_pkg::PH_ADDRESS: begin
        ee_addr  = {ee_addr[10:8], shreg};
        bit_cnt  = i2cee_pkg::BYTE_BITS;
        ph       = i2cee_pkg::PH_WRITE;
        ack_wait = 1'b1;
        fill_cnt = '0;
      end
      i2cee_pkg::PH_WRITE: begin
        pg_buf[fill_cnt] = shreg;
        fill_cnt         = fill_cnt + 1'b1;
        bit_cnt          = i2cee_pkg::BYTE_BITS;
        ack_wait         = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic predict_port(input logic [i2cee_pkg::PORT_W-1:0] v, output logic drive);
    logic sda, wp, scl;
    sda = v[i2cee_pkg::SDA_BIT];
    wp  = v[i2cee_pkg::WP_BIT];
    scl = v[i2cee_pkg::SCL_BIT];
    if (!scl_q && scl) begin
      started = 1'b1;
      if (tx_on && !ack_wait && bit_cnt == 0) begin
        shreg   = ee_mem[ee_addr];
        ee_addr = ee_addr + 1'b1;
        bit_cnt = i2cee_pkg::BYTE_BITS;
      end
    end else if (scl_q && scl) begin
      if (sda_q && !sda) begin
        started = 1'b0;
        tx_on   = 1'b0;
        rx_on   = 1'b1;
        ph      = i2cee_pkg::PH_SELECT;
        bit_cnt = i2cee_pkg::BYTE_BITS;
      end else if (!sda_q && sda) begin
        if (ph == i2cee_pkg::PH_WRITE && !wp) begin
          for (int k = 0; k < int'(fill_cnt); k++) begin
            ee_mem[ee_addr] = pg_buf[k];
            if (ee_addr[7:0] == i2cee_pkg::PAGE_END) ee_addr = ee_addr & i2cee_pkg::BLOCK_MASK;
            else ee_addr = ee_addr + 1'b1;
          end
        end
        ph      = i2cee_pkg::PH_IDLE;
        started = 1'b0;
        rx_on   = 1'b0;
        tx_on   = 1'b0;
      end
    end else if (scl_q && !scl) begin
      if (ack_wait) begin
        ack_wait = 1'b0;
      end else if (tx_on) begin
        shreg = shreg << 1;
      end else if (rx_on && started) begin
        shreg   = {shreg[6:0], sda_q};
        bit_cnt = bit_cnt - 1'b1;
        if (bit_cnt == 0) finish_byte();
      end
    end
    sda_q = sda;
    scl_q = scl;
    drive = (!ack_wait && ph != i2cee_pkg::PH_IDLE && tx_on) ? shreg[7] : 1'b0;
  endtask

  // bus item builders: ignored port bits are random
  task automatic push_port(input logic scl, input logic sda);
    port_seq.push_back('{{1'($urandom), scl, wp_now, sda, 4'($urandom)}, FROM_MODEL});
  endtask

  task automatic bus_bit(input logic b);
    push_port(1'b0, b);
    push_port(1'b1, b);
  endtask

  task automatic bus_start();
    push_port(1'b0, 1'b1);
    push_port(1'b1, 1'b1);
    push_port(1'b1, 1'b0);
  endtask

  task automatic bus_stop();
    push_port(1'b0, 1'b0);
    push_port(1'b1, 1'b0);
    push_port(1'b1, 1'b1);
  endtask

  // 8 data bits then the ack clock with the line released
  task automatic bus_byte(input logic [7:0] b);
    for (int i = 7; i >= 0; i--) bus_bit(b[i]);
    bus_bit(1'b1);
  endtask

  initial begin
    int          kind;
    int          nb;
    int          gap;
    int          mode;
    logic [2:0]  blk;
    logic [7:0]  addr;
    logic [7:0]  sel;
    logic        drv;
    sda_q    = 1'b1;
    scl_q    = 1'b1;
    ph       = i2cee_pkg::PH_IDLE;
    started  = 1'b0;
    tx_on    = 1'b0;
    rx_on    = 1'b0;
    ack_wait = 1'b0;
    bit_cnt  = '0;
    shreg    = '0;
    ee_addr  = '0;
    fill_cnt = '0;
    foreach (pg_buf[i]) pg_buf[i] = '0;
    foreach (ee_mem[i]) ee_mem[i] = '0;
    mode     = 0;

    foreach (dir_rows[i]) port_seq.push_back(dir_rows[i]);
    while (port_seq.size() < $size(dir_rows) + N_RANDOM) begin
      kind   = $urandom_range(0, 99);
      wp_now = ($urandom_range(0, 4) == 0);
      blk    = ($urandom_range(0, 1) == 0) ? 3'd0 : 3'($urandom);
      addr   = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(240, 255)) : 8'($urandom);
      if (kind < 40) begin
        bus_start();
        bus_byte({i2cee_pkg::DEV_TYPE, blk, 1'b0});
        bus_byte(addr);
        nb = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 6);
        repeat (nb) bus_byte(8'($urandom));
        if ($urandom_range(0, 7) != 0) bus_stop();
      end else if (kind < 75) begin
        bus_start();
        bus_byte({i2cee_pkg::DEV_TYPE, blk, 1'b0});
        bus_byte(addr);
        bus_start();
        bus_byte({i2cee_pkg::DEV_TYPE, 3'($urandom), 1'b1});
        repeat ($urandom_range(1, 3)) bus_byte(8'hFF);
        bus_stop();
      end else if (kind < 85) begin
        bus_start();
        bus_byte({i2cee_pkg::DEV_TYPE, 3'($urandom), 1'b1});
        bus_byte(8'hFF);
        bus_stop();
      end else if (kind < 93) begin
        sel = 8'($urandom);
        if (sel[7:4] == i2cee_pkg::DEV_TYPE) sel[7] = ~sel[7];
        bus_start();
        bus_byte(sel);
        if ($urandom_range(0, 1) == 0) bus_stop();
      end else begin
        repeat ($urandom_range(1, 8)) port_seq.push_back('{8'($urandom), FROM_MODEL});
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    foreach (port_seq[i]) begin
      if (i % 50 == 0) mode = $urandom_range(0, 2);
      gap = pick_wait(mode);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid      <= 1'b1;
      in_port_value <= port_seq[i].port;
      do @(posedge clk); while (in_stall);
      predict_port(port_seq[i].port, drv);
      drive_exp_q.push_back((port_seq[i].typed == FROM_MODEL) ? drv : port_seq[i].typed[0]);
      n_acc++;
    end
    in_valid <= 1'b0;
    while (drive_exp_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (n_err == 0) $display("tb_i2c_eeprom_2kb_slave_core OK");
    else $display("tb_i2c_eeprom_2kb_slave_core NOT OK");
    $finish;
  end

  always @(posedge clk) begin
    logic exp_drive;
    if (rst_n && out_valid && !out_stall) begin
      if (n_out % 50 == 0) rx_mode = $urandom_range(0, 2);
      if (drive_exp_q.size() == 0) begin
        flag_error($sformatf("item %0d: result with nothing expected, got %0b",
                             n_out, out_data_line_out));
      end else begin
        exp_drive = drive_exp_q.pop_front();
        if (out_data_line_out !== exp_drive)
          flag_error($sformatf("item %0d: data_line_out expected %0b, got %0b",
                               n_out, exp_drive, out_data_line_out));
      end
      n_out++;
      rx_wait = pick_wait(rx_mode);
    end else if (rx_wait > 0) begin
      rx_wait--;
    end
    out_stall <= (rx_wait > 0) || hold_off;
  end

  // long receiver hold-off so the core backs up and stalls its input
  initial begin
    wait (n_acc >= 300);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    while (cyc_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc_cnt++;
    end
    $display("tb_i2c_eeprom_2kb_slave_core NOT OK");
    $finish;
  end

endmodule

[i2c_eeprom_2kb_slave_core.f]
rtl/i2cee_pkg.sv
rtl/i2cee_dp.sv
rtl/i2cee_ctrl.sv
rtl/i2c_eeprom_2kb_slave_core.sv
test/tb_i2c_eeprom_2kb_slave_core.sv
